// ===== src/ial_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ial_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  entry_value;
    } ial_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]  count;
    } ial_out_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             srch;
        logic             rd;
        logic [POS_W-1:0] pos;
    } ial_ctl_t;

endpackage

`default_nettype wire

// ===== src/ial_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ial_cell #(
    parameter int KEY_W = 32,
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  wire logic                clk,
    input  wire ial_pkg::ial_ctl_t   ctl,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [CNT_W-1:0]    count,
    input  wire logic [KEY_W-1:0]    left,
    input  wire logic [KEY_W-1:0]    right,
    output logic      [KEY_W-1:0]    entry,
    output logic                     hit,
    output logic      [KEY_W-1:0]    rd_data
);
    import ial_pkg::*;

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    logic             hit_reg;
    logic             hit_next;
    logic [KEY_W-1:0] rd_reg;
    logic [KEY_W-1:0] rd_next;
    logic             after_pos;
    logic             at_pos;
    logic             live;

    assign after_pos = int'(ctl.pos) < INDEX;
    assign at_pos    = int'(ctl.pos) == INDEX;
    assign live      = int'(count) > INDEX;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (after_pos)
                entry_next = left;
            else if (at_pos)
                entry_next = key;
        end
        else if (ctl.del)
        begin
            if (after_pos || at_pos)
                entry_next = right;
        end
        hit_next = ctl.srch && live && (entry_reg == key);
        rd_next  = (ctl.rd && at_pos) ? entry_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
        rd_reg    <= rd_next;
    end

    assign entry   = entry_reg;
    assign hit     = hit_reg;
    assign rd_data = rd_reg;

endmodule

`default_nettype wire

// ===== src/indexed_array_list.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY keys held in a row of cells. Insert, delete,
// search and read each take one request per clock: busy stays low, so a
// request is taken at every edge where start is high. The cells shift and
// compare all entries at once and register their match and read data, and
// the merged match and read data are then registered into result as done
// rises. The receiver cannot stall: capture result in the cycle done is
// high.
module indexed_array_list #(
    parameter int CAPACITY  = ial_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ial_pkg::KEY_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ial_pkg::ial_in_t  request,
    output logic                   done,
    output ial_pkg::ial_out_t      result
);
    import ial_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 s1_valid_reg;
    logic [STATUS_W-1:0]  s1_status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [CNT_W-1:0]     s1_count_reg;
    logic                 done_reg;
    ial_out_t             result_reg;
    ial_out_t             result_next;

    ial_ctl_t             ctl;
    logic [KEY_WIDTH-1:0] key;
    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic                 pos_gt_cnt;
    logic                 pos_ge_cnt;

    logic [KEY_WIDTH-1:0] ent  [CAPACITY];
    logic [KEY_WIDTH-1:0] rdv  [CAPACITY];
    logic [CAPACITY-1:0]  hits;
    logic [KEY_WIDTH-1:0] rd_merge;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign key    = KEY_WIDTH'(request.entry_value);

    assign is_full    = count_reg >= CNT_W'(CAPACITY);
    assign is_empty   = count_reg == '0;
    assign pos_gt_cnt = int'(request.position) > int'(count_reg);
    assign pos_ge_cnt = int'(request.position) >= int'(count_reg);

    always_comb
    begin
        ctl         = '0;
        ctl.pos     = request.position;
        status_next = ST_OK;
        count_next  = count_reg;
        case (request.action)
            ACT_INSERT:
            begin
                if (is_full)
                    status_next = ST_FULL;
                else if (pos_gt_cnt)
                    status_next = ST_RANGE;
                else
                begin
                    ctl.ins    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_DELETE:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else if (pos_ge_cnt)
                    status_next = ST_RANGE;
                else
                begin
                    ctl.del    = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_SEARCH:
            begin
                ctl.srch = accept;
            end
            ACT_READ:
            begin
                if (pos_ge_cnt)
                    status_next = ST_RANGE;
                else
                    ctl.rd = accept;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] left_in;
        logic [KEY_WIDTH-1:0] right_in;

        if (k == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = ent[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = ent[k+1];
        end

        ial_cell #(
            .KEY_W (KEY_WIDTH),
            .CNT_W (CNT_W),
            .INDEX (k)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .key     (key),
            .count   (count_reg),
            .left    (left_in),
            .right   (right_in),
            .entry   (ent[k]),
            .hit     (hits[k]),
            .rd_data (rdv[k])
        );
    end

    // Only the addressed cell drives nonzero read data
    always_comb
    begin
        rd_merge = '0;
        for (int k = 0; k < CAPACITY; k++)
            rd_merge = rd_merge | rdv[k];
    end

    always_comb
    begin
        result_next            = '0;
        result_next.status     = s1_status_reg;
        result_next.found      = |hits;
        result_next.read_value = VALUE_W'(rd_merge);
        result_next.count      = COUNT_W'(s1_count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_next;
            s1_count_reg  <= count_next;
        end
        if (s1_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ial_pkg::*;

    localparam int WATCHDOG_LIMIT = 200;
    localparam int RANDOM_ITEMS   = 400;

    // Mirror of the list plus the queue of results still owed by the block
    class list_scoreboard;
        logic [VALUE_W-1:0] slots [CAPACITY_DEF];
        int unsigned        fill;
        ial_out_t           expected_results [$];
        int unsigned        mismatches;

        function new();
            fill = 0;
            mismatches = 0;
            foreach (slots[i])
            begin
                slots[i] = '0;
            end
        endfunction

        task report(input string what, input logic [39:0] got, input logic [39:0] want);
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        // Apply one accepted request to the mirror and queue its result
        function void note_request(input ial_in_t req);
            ial_out_t r;
            int       k;
            int       pos;
            r = '0;
            r.status = ST_OK;
            pos = int'(req.position);
            case (req.action)
                ACT_INSERT:
                begin
                    if (fill >= CAPACITY_DEF)
                        r.status = ST_FULL;
                    else if (pos > int'(fill))
                        r.status = ST_RANGE;
                    else
                    begin
                        for (k = int'(fill); k > pos; k--)
                            slots[k] = slots[k-1];
                        slots[pos] = req.entry_value;
                        fill++;
                    end
                end
                ACT_DELETE:
                begin
                    if (fill == 0)
                        r.status = ST_EMPTY;
                    else if (pos >= int'(fill))
                        r.status = ST_RANGE;
                    else
                    begin
                        for (k = pos; k + 1 < int'(fill); k++)
                            slots[k] = slots[k+1];
                        fill--;
                    end
                end
                ACT_SEARCH:
                begin
                    for (k = 0; k < int'(fill); k++)
                        if (slots[k] == req.entry_value)
                            r.found = 1'b1;
                end
                default:
                begin
                    if (pos >= int'(fill))
                        r.status = ST_RANGE;
                    else
                        r.read_value = slots[pos];
                end
            endcase
            r.count = COUNT_W'(fill);
            expected_results.push_back(r);
        endfunction

        task check_result(input ial_out_t got);
            ial_out_t want;
            if (expected_results.size() == 0)
            begin
                report("unexpected result", 40'(got), '0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report("status", 40'(got.status), 40'(want.status));
                if (got.found !== want.found)
                    report("found", 40'(got.found), 40'(want.found));
                if (got.read_value !== want.read_value)
                    report("read_value", 40'(got.read_value), 40'(want.read_value));
                if (got.count !== want.count)
                    report("count", 40'(got.count), 40'(want.count));
            end
        endtask
    endclass

    typedef enum int { GROW, SHRINK, MIX } trend_e;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    ial_in_t  request = '0;
    logic     busy;
    logic     done;
    ial_out_t result;

    list_scoreboard sb;
    int unsigned    quiet_cycles = 0;
    int             no_gap_left = 0;
    trend_e         trend = GROW;

    indexed_array_list dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Check results before noting the request taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(request);
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int draw_gap();
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            no_gap_left = $urandom_range(5, 30);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Hold start high until the request is taken
    task automatic send_request(input ial_in_t req);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic issue(input logic [ACTION_W-1:0] act, input int pos,
                         input logic [VALUE_W-1:0] value);
        ial_in_t req;
        req.action = act;
        req.position = POS_W'(pos);
        req.entry_value = value;
        send_request(req);
    endtask

    function automatic logic [VALUE_W-1:0] pool_key();
        return VALUE_W'($urandom_range(0, 7)) * 32'h1111_1111;
    endfunction

    function automatic ial_in_t pick_request();
        ial_in_t req;
        int      n;
        int      roll;
        int      ins_w;
        int      del_w;
        n = int'(sb.fill);
        if (n >= CAPACITY_DEF)
            trend = SHRINK;
        else if (n == 0)
            trend = GROW;
        else if ($urandom_range(0, 99) < 3)
            trend = trend_e'($urandom_range(0, 2));
        case (trend)
            GROW:    begin ins_w = 55; del_w = 15; end
            SHRINK:  begin ins_w = 15; del_w = 55; end
            default: begin ins_w = 30; del_w = 20; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_w)
            req.action = ACT_INSERT;
        else if (roll < ins_w + del_w)
            req.action = ACT_DELETE;
        else if (roll < ins_w + del_w + (100 - ins_w - del_w) / 2)
            req.action = ACT_SEARCH;
        else
            req.action = ACT_READ;

        // Mostly legal positions, the rest anywhere in the field
        if ($urandom_range(0, 99) < 85)
        begin
            if (req.action == ACT_INSERT)
                req.position = POS_W'($urandom_range(0, n));
            else
                req.position = (n > 0) ? POS_W'($urandom_range(0, n - 1)) : '0;
        end
        else
            req.position = POS_W'($urandom_range(0, 31));

        roll = $urandom_range(0, 99);
        if (req.action == ACT_SEARCH && n > 0 && roll < 50)
            req.entry_value = sb.slots[$urandom_range(0, n - 1)];
        else if ((req.action == ACT_SEARCH || req.action == ACT_INSERT) && roll < 75)
            req.entry_value = pool_key();
        else
            req.entry_value = $urandom;
        return req;
    endfunction

    task automatic run_directed();
        int i;
        // Empty list corners
        issue(ACT_READ, 0, '0);
        issue(ACT_DELETE, 31, '1);
        issue(ACT_SEARCH, 0, '0);
        issue(ACT_INSERT, 1, '1);
        // Build a short list and probe it
        issue(ACT_INSERT, 0, '1);
        issue(ACT_INSERT, 0, '0);
        issue(ACT_INSERT, 2, 32'hA5A5_5A5A);
        issue(ACT_SEARCH, 0, '1);
        issue(ACT_SEARCH, 0, 32'h1234_5678);
        issue(ACT_READ, 2, '0);
        issue(ACT_READ, 3, '0);
        issue(ACT_DELETE, 3, '0);
        issue(ACT_DELETE, 1, '0);
        // Fill to capacity, then hit the full and end-of-list cases
        for (i = 2; i < CAPACITY_DEF; i++)
            issue(ACT_INSERT, $urandom_range(0, i), $urandom);
        issue(ACT_INSERT, 31, '1);
        issue(ACT_READ, 15, '0);
        issue(ACT_READ, 16, '0);
        issue(ACT_DELETE, 16, '0);
        issue(ACT_DELETE, 0, '0);
        issue(ACT_DELETE, 14, '0);
    endtask

    initial
    begin
        int i;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (i = 0; i < RANDOM_ITEMS; i++)
            send_request(pick_request());
        start <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ial_pkg.sv
src/ial_cell.sv
src/indexed_array_list.sv
tb/tb_top.sv
